FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands on i_clk, disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define QXM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define QXM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/qxm_pkg.sv
// ----------------------------------------------------------------------------
// qxm_pkg
// Types, codes and helpers shared by the quad-X motor mixer.
// ----------------------------------------------------------------------------
package qxm_pkg;

    localparam int CMD_W    = 15;   // motor command
    localparam int PULSE_W  = 12;   // pulse width, us
    localparam int EFF_W    = 16;   // effort input
    localparam int ANG_W    = 12;   // angle input
    localparam int PROD_W   = 29;   // shared multiplier output
    localparam int CORR_W   = 25;   // scaled correction
    localparam int SUM_W    = 27;   // mix sum
    localparam int DIVD_W   = 27;   // pulse dividend
    localparam int QUO_W    = 13;   // quotient, top bit flags >= 4096
    localparam int CFG_DW   = 15;
    localparam int CFG_AW   = 3;

    typedef enum logic [1:0] {
        REQ_ARM    = 2'd0,
        REQ_DISARM = 2'd1,
        REQ_MIX    = 2'd2,
        REQ_TILT   = 2'd3
    } t_req;

    typedef enum logic [2:0] {
        REG_CMD_MIN    = 3'd0,
        REG_CMD_MAX    = 3'd1,
        REG_FULL_SCALE = 3'd2,
        REG_PULSE_MIN  = 3'd3,
        REG_PULSE_RNG  = 3'd4,
        REG_PULSE_MAX  = 3'd5,
        REG_TILT_LIM   = 3'd6,
        REG_GAIN       = 3'd7
    } t_reg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCALE,
        S_SCALE_WB,
        S_MIX,
        S_PMUL,
        S_PSTART,
        S_PWAIT,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd_min;
        logic [CMD_W-1:0]   cmd_max;
        logic [CMD_W-1:0]   full_scale;
        logic [PULSE_W-1:0] pulse_min;
        logic [PULSE_W-1:0] pulse_range;
        logic [PULSE_W-1:0] pulse_max;
        logic [10:0]        tilt_limit;
        logic [7:0]         gain;
    } t_cfg;

    // clamp to [lo, hi]; lo is tested first, so an inverted range still resolves
    function automatic logic [CMD_W-1:0] f_limit(
        input logic signed [SUM_W-1:0] v,
        input logic [CMD_W-1:0]        lo,
        input logic [CMD_W-1:0]        hi
    );
        logic signed [SUM_W-1:0] slo;
        logic signed [SUM_W-1:0] shi;
        logic [CMD_W-1:0]        res;
        slo = signed'({{(SUM_W-CMD_W){1'b0}}, lo});
        shi = signed'({{(SUM_W-CMD_W){1'b0}}, hi});
        if (v < slo) begin
            res = lo;
        end else if (v > shi) begin
            res = hi;
        end else begin
            res = v[CMD_W-1:0];
        end
        return res;
    endfunction

endpackage

FILE: rtl/qxm_cfg_regs.sv
// ----------------------------------------------------------------------------
// qxm_cfg_regs
// Configuration register file; one write beat per cycle, always ready.
// ----------------------------------------------------------------------------
module qxm_cfg_regs import qxm_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [CFG_AW-1:0] i_cfg_index,
    input  logic [CFG_DW-1:0] i_cfg_data,
    output t_cfg              o_cfg
);

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cmd_min     <= 15'd0;
            r_cfg.cmd_max     <= 15'd800;
            r_cfg.full_scale  <= 15'd1000;
            r_cfg.pulse_min   <= 12'd1000;
            r_cfg.pulse_range <= 12'd1000;
            r_cfg.pulse_max   <= 12'd2000;
            r_cfg.tilt_limit  <= 11'd450;
            r_cfg.gain        <= 8'd50;
        end else if (i_cfg_valid) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_CMD_MIN:    r_cfg.cmd_min     <= i_cfg_data;
                REG_CMD_MAX:    r_cfg.cmd_max     <= i_cfg_data;
                REG_FULL_SCALE: r_cfg.full_scale  <= i_cfg_data;
                REG_PULSE_MIN:  r_cfg.pulse_min   <= i_cfg_data[PULSE_W-1:0];
                REG_PULSE_RNG:  r_cfg.pulse_range <= i_cfg_data[PULSE_W-1:0];
                REG_PULSE_MAX:  r_cfg.pulse_max   <= i_cfg_data[PULSE_W-1:0];
                REG_TILT_LIM:   r_cfg.tilt_limit  <= i_cfg_data[10:0];
                REG_GAIN:       r_cfg.gain        <= i_cfg_data[7:0];
                default:        r_cfg.gain        <= r_cfg.gain;
            endcase
        end
    end

endmodule

FILE: rtl/qxm_divider.sv
// ----------------------------------------------------------------------------
// qxm_divider
// Restoring divider, one quotient bit per cycle, 13 steps. Only the low
// 12 quotient bits are exact; the top bit says the quotient is >= 4096.
// ----------------------------------------------------------------------------
module qxm_divider import qxm_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DIVD_W-1:0] i_dividend,
    input  logic [CMD_W-1:0]  i_divisor,
    output logic              o_done,
    output logic [QUO_W-1:0]  o_quotient
);

    logic              r_busy;
    logic              r_done;
    logic [3:0]        r_step;
    logic [DIVD_W-1:0] r_rem;
    logic [DIVD_W-1:0] r_dsh;
    logic [QUO_W-1:0]  r_quo;
    logic [CMD_W-1:0]  dvs;
    logic              ge;

    // zero full scale divides as one
    assign dvs = (i_divisor == '0) ? CMD_W'(1) : i_divisor;
    assign ge  = (r_rem >= r_dsh);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= 4'(QUO_W - 1);
            end else if (r_busy) begin
                if (r_step == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_step <= r_step - 4'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_dividend;
            r_dsh <= {dvs, {(DIVD_W-CMD_W){1'b0}}};
            r_quo <= '0;
        end else if (r_busy) begin
            if (ge) begin
                r_rem <= r_rem - r_dsh;
            end
            r_quo <= {r_quo[QUO_W-2:0], ge};
            r_dsh <= r_dsh >> 1;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

FILE: rtl/quad_x_motor_mixer.sv
// ----------------------------------------------------------------------------
// quad_x_motor_mixer
// Quad-X mixer with arm/disarm, tilt cutoff and pulse-width conversion,
// built around one shared multiplier and a bit-serial divider.
// ----------------------------------------------------------------------------
//  channel   handshake                  payload
//  request   i_valid / o_stall          i_req_type .. i_pitch_angle
//  result    o_valid / i_stall          o_pulse_* , o_is_armed, o_tilt_ok
//  config    i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
//  One request at a time; o_stall is high from accept until the result beat.
//  Armed results go through pulse conversion (per motor: multiply, divider start,
//  13 divider steps, done), after a mix update (3 scales, 4 sums) on a mix.
//  Disarmed results come back the cycle after accept. i_stall holds the result.
//  Reset (sync, low): disarmed, commands zero, registers to defaults.
// ----------------------------------------------------------------------------
module quad_x_motor_mixer import qxm_pkg::*; #(
    parameter int EFFORT_FRACTION_BITS = 8
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic [1:0]               i_req_type,
    input  logic signed [EFF_W-1:0]  i_throttle_cmd,
    input  logic signed [EFF_W-1:0]  i_roll_effort,
    input  logic signed [EFF_W-1:0]  i_pitch_effort,
    input  logic signed [EFF_W-1:0]  i_yaw_effort,
    input  logic signed [ANG_W-1:0]  i_roll_angle,
    input  logic signed [ANG_W-1:0]  i_pitch_angle,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic [PULSE_W-1:0]       o_pulse_rear_right,
    output logic [PULSE_W-1:0]       o_pulse_front_left,
    output logic [PULSE_W-1:0]       o_pulse_front_right,
    output logic [PULSE_W-1:0]       o_pulse_rear_left,
    output logic                     o_is_armed,
    output logic                     o_tilt_ok,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CFG_AW-1:0]        i_cfg_index,
    input  logic [CFG_DW-1:0]        i_cfg_data
);

    localparam logic signed [PROD_W-1:0] L_BIAS =
        (PROD_W'(1) << EFFORT_FRACTION_BITS) - PROD_W'(1);

    t_cfg   cfg;
    t_state r_state, n_state;

    logic                     r_armed;
    logic                     r_tilt_ok;
    logic [1:0]               r_idx;
    logic [CMD_W-1:0]         r_thr;
    logic signed [EFF_W-1:0]  r_eff_r, r_eff_p, r_eff_y;
    logic signed [CORR_W-1:0] r_cor_r, r_cor_p, r_cor_y;
    logic [CMD_W-1:0]         r_cmd [4];     // FR, FL, RR, RL
    logic [PULSE_W-1:0]       r_pulse [4];
    logic signed [PROD_W-1:0] r_prod;

    logic                     accept;
    logic                     tilt_fail;
    logic [ANG_W-1:0]         mag_r, mag_p;
    logic signed [EFF_W-1:0]  mul_a;
    logic signed [QUO_W-1:0]  mul_b;
    logic signed [PROD_W-1:0] mul_p;
    logic signed [PROD_W-1:0] scl_sum;
    logic signed [CORR_W-1:0] corr_val;
    logic signed [SUM_W-1:0]  s_t, s_r, s_p, s_y, mix_sum;
    logic                     div_start, div_done;
    logic [QUO_W-1:0]         div_q;
    logic [13:0]              pls_sum;
    logic [PULSE_W-1:0]       pls_cap;

    qxm_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    qxm_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_prod[DIVD_W-1:0]),
        .i_divisor  (cfg.full_scale),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    assign o_stall = (r_state != S_IDLE);
    assign accept  = i_valid && !o_stall;

    // tilt magnitudes; -2048 still fits as 12-bit unsigned
    assign mag_r     = i_roll_angle[ANG_W-1]  ? ANG_W'(-i_roll_angle)  : i_roll_angle;
    assign mag_p     = i_pitch_angle[ANG_W-1] ? ANG_W'(-i_pitch_angle) : i_pitch_angle;
    assign tilt_fail = (mag_r > {1'b0, cfg.tilt_limit}) || (mag_p > {1'b0, cfg.tilt_limit});

    // shared multiplier: effort x gain, or command x pulse range
    always_comb begin
        if (r_state == S_SCALE) begin
            case (r_idx)
                2'd0:    mul_a = r_eff_r;
                2'd1:    mul_a = r_eff_p;
                default: mul_a = r_eff_y;
            endcase
            mul_b = signed'({5'b0, cfg.gain});
        end else begin
            mul_a = signed'({1'b0, r_cmd[r_idx]});
            mul_b = signed'({1'b0, cfg.pulse_range});
        end
    end
    assign mul_p = mul_a * mul_b;

    // shift right with truncation toward zero
    assign scl_sum  = r_prod + (r_prod[PROD_W-1] ? L_BIAS : '0);
    assign corr_val = CORR_W'(scl_sum >>> EFFORT_FRACTION_BITS);

    assign s_t = signed'({{(SUM_W-CMD_W){1'b0}}, r_thr});
    assign s_r = SUM_W'(r_cor_r);
    assign s_p = SUM_W'(r_cor_p);
    assign s_y = SUM_W'(r_cor_y);

    always_comb begin
        case (r_idx)
            2'd0:    mix_sum = s_t + s_p - s_r - s_y;   // front right
            2'd1:    mix_sum = s_t + s_p + s_r + s_y;   // front left
            2'd2:    mix_sum = s_t - s_p - s_r + s_y;   // rear right
            default: mix_sum = s_t - s_p + s_r - s_y;   // rear left
        endcase
    end

    // quotient top bit means >= 4096, which is past any cap anyway
    assign pls_sum = {2'b0, cfg.pulse_min}
                   + (div_q[QUO_W-1] ? 14'd4096 : {2'b0, div_q[PULSE_W-1:0]});
    assign pls_cap = (pls_sum > {2'b0, cfg.pulse_max}) ? cfg.pulse_max
                                                       : pls_sum[PULSE_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        div_start = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (t_req'(i_req_type))
                        REQ_ARM:    n_state = S_PMUL;
                        REQ_DISARM: n_state = S_DONE;
                        REQ_MIX:    n_state = r_armed ? S_SCALE : S_DONE;
                        REQ_TILT:   n_state = (tilt_fail || !r_armed) ? S_DONE : S_PMUL;
                        default:    n_state = S_DONE;
                    endcase
                end
            end
            S_SCALE:    n_state = S_SCALE_WB;
            S_SCALE_WB: n_state = (r_idx == 2'd2) ? S_MIX : S_SCALE;
            S_MIX:      n_state = (r_idx == 2'd3) ? S_PMUL : S_MIX;
            S_PMUL:     n_state = S_PSTART;
            S_PSTART: begin
                div_start = 1'b1;
                n_state   = S_PWAIT;
            end
            S_PWAIT: begin
                if (div_done) begin
                    n_state = (r_idx == 2'd3) ? S_DONE : S_PMUL;
                end
            end
            S_DONE: begin
                if (!i_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed <= 1'b0;
            r_idx   <= '0;
            for (int k = 0; k < 4; k++) begin
                r_cmd[k] <= '0;
            end
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    r_idx <= '0;
                    if (accept) begin
                        unique case (t_req'(i_req_type))
                            REQ_ARM: r_armed <= 1'b1;
                            REQ_DISARM: begin
                                r_armed <= 1'b0;
                                for (int k = 0; k < 4; k++) r_cmd[k] <= '0;
                            end
                            REQ_MIX: begin
                                if (!r_armed) begin
                                    for (int k = 0; k < 4; k++) r_cmd[k] <= '0;
                                end
                            end
                            REQ_TILT: begin
                                if (tilt_fail) begin
                                    r_armed <= 1'b0;
                                    for (int k = 0; k < 4; k++) r_cmd[k] <= '0;
                                end
                            end
                            default: r_armed <= r_armed;
                        endcase
                    end
                end
                S_SCALE_WB: r_idx <= (r_idx == 2'd2) ? 2'd0 : r_idx + 2'd1;
                S_MIX: begin
                    r_cmd[r_idx] <= f_limit(mix_sum, cfg.cmd_min, cfg.cmd_max);
                    r_idx        <= r_idx + 2'd1;
                end
                S_PWAIT: begin
                    if (div_done) begin
                        r_idx <= r_idx + 2'd1;
                    end
                end
                default: r_idx <= r_idx;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_eff_r   <= i_roll_effort;
            r_eff_p   <= i_pitch_effort;
            r_eff_y   <= i_yaw_effort;
            r_thr     <= f_limit(SUM_W'(i_throttle_cmd), cfg.cmd_min, cfg.cmd_max);
            r_tilt_ok <= !((t_req'(i_req_type) == REQ_TILT) && tilt_fail);
        end
        if (r_state == S_SCALE || r_state == S_PMUL) begin
            r_prod <= mul_p;
        end
        if (r_state == S_SCALE_WB) begin
            case (r_idx)
                2'd0:    r_cor_r <= corr_val;
                2'd1:    r_cor_p <= corr_val;
                default: r_cor_y <= corr_val;
            endcase
        end
        if (r_state == S_PWAIT && div_done) begin
            r_pulse[r_idx] <= pls_cap;
        end
    end

    assign o_valid             = (r_state == S_DONE);
    assign o_is_armed          = r_armed;
    assign o_tilt_ok           = r_tilt_ok;
    assign o_pulse_rear_right  = r_armed ? r_pulse[2] : cfg.pulse_min;
    assign o_pulse_front_left  = r_armed ? r_pulse[1] : cfg.pulse_min;
    assign o_pulse_front_right = r_armed ? r_pulse[0] : cfg.pulse_min;
    assign o_pulse_rear_left   = r_armed ? r_pulse[3] : cfg.pulse_min;

`include "assert_macros.svh"

    `QXM_ASSERT_NOW(a_busy_while_result, o_valid, o_stall, "result beat while taking requests")
    `QXM_ASSERT_NOW(a_fail_disarms, o_valid && !o_tilt_ok, !o_is_armed, "failed tilt left block armed")
    `QXM_ASSERT_NOW(a_armed_capped, o_valid && o_is_armed, (o_pulse_front_left <= cfg.pulse_max) && (o_pulse_rear_left <= cfg.pulse_max), "armed pulse above cap")
    `QXM_ASSERT_NEXT(a_one_beat, o_valid && !i_stall, !o_valid, "result beat repeated")

endmodule

FILE: test/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for quad_x_motor_mixer. A scoreboard class mirrors the
// arm state, stored motor commands and registers, predicts the four pulse
// widths and flags of every accepted request beat, and checks each result
// beat in order. Runs a directed sequence, then register phases (defaults,
// a mid set, extremes, all zeros, inverted limits, random) with random
// request streams under random valid/stall bursts, none in the last phase.
// ----------------------------------------------------------------------------
module tb import qxm_pkg::*; ();

    localparam int FRAC_BITS       = 8;
    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 200;
    localparam int RX_HOLD_CYCLES  = 300;
    localparam int SETTLE_CYCLES   = 80;
    localparam int WATCHDOG_LIMIT  = 4000;

    typedef struct {
        t_req               req;
        logic signed [15:0] throttle;
        logic signed [15:0] roll;
        logic signed [15:0] pitch;
        logic signed [15:0] yaw;
        logic signed [11:0] roll_ang;
        logic signed [11:0] pitch_ang;
    } t_mix_req;

    typedef struct {
        logic [11:0] rear_right;
        logic [11:0] front_left;
        logic [11:0] front_right;
        logic [11:0] rear_left;
        logic        armed;
        logic        tilt_ok;
    } t_pulse_set;

    class motor_pulse_tracker;
        t_cfg        cfg;
        bit          armed;
        logic [15:0] cmd [4];     // FR, FL, RR, RL
        t_pulse_set  pulse_due [$];
        int          mismatches;

        function new();
            cfg.cmd_min     = 15'd0;
            cfg.cmd_max     = 15'd800;
            cfg.full_scale  = 15'd1000;
            cfg.pulse_min   = 12'd1000;
            cfg.pulse_range = 12'd1000;
            cfg.pulse_max   = 12'd2000;
            cfg.tilt_limit  = 11'd450;
            cfg.gain        = 8'd50;
            mismatches      = 0;
            disarm();
        endfunction

        function void disarm();
            armed = 1'b0;
            foreach (cmd[k]) cmd[k] = '0;
        endfunction

        function void apply_reg(t_reg_idx idx, logic [CFG_DW-1:0] data);
            case (idx)
                REG_CMD_MIN:    cfg.cmd_min     = data;
                REG_CMD_MAX:    cfg.cmd_max     = data;
                REG_FULL_SCALE: cfg.full_scale  = data;
                REG_PULSE_MIN:  cfg.pulse_min   = data[11:0];
                REG_PULSE_RNG:  cfg.pulse_range = data[11:0];
                REG_PULSE_MAX:  cfg.pulse_max   = data[11:0];
                REG_TILT_LIM:   cfg.tilt_limit  = data[10:0];
                REG_GAIN:       cfg.gain        = data[7:0];
                default: ;
            endcase
        endfunction

        // low bound wins when the range is inverted
        function longint clamp_cmd(longint v);
            if (v < longint'(cfg.cmd_min)) return longint'(cfg.cmd_min);
            if (v > longint'(cfg.cmd_max)) return longint'(cfg.cmd_max);
            return v;
        endfunction

        // truncate toward zero, not floor
        function longint scale_effort(logic signed [15:0] e);
            longint prod;
            longint mag;
            prod = longint'(e) * longint'(cfg.gain);
            mag  = (prod < 0) ? -prod : prod;
            mag  = mag >>> FRAC_BITS;
            return (prod < 0) ? -mag : mag;
        endfunction

        function logic [11:0] cmd_to_pulse(logic [15:0] c);
            longint fs;
            longint p;
            fs = (cfg.full_scale == 0) ? 1 : longint'(cfg.full_scale);
            p  = longint'(cfg.pulse_min) + (longint'(c) * longint'(cfg.pulse_range)) / fs;
            if (p > longint'(cfg.pulse_max)) p = longint'(cfg.pulse_max);
            return p[11:0];
        endfunction

        function void note_request(t_mix_req r);
            t_pulse_set exp_set;
            longint     t, rc, pc, yc, ra, pa;
            exp_set.tilt_ok = 1'b1;
            case (r.req)
                REQ_ARM:    armed = 1'b1;
                REQ_DISARM: disarm();
                REQ_MIX: begin
                    if (!armed) begin
                        disarm();
                    end else begin
                        t  = clamp_cmd(longint'(r.throttle));
                        rc = scale_effort(r.roll);
                        pc = scale_effort(r.pitch);
                        yc = scale_effort(r.yaw);
                        cmd[0] = 16'(clamp_cmd(t + pc - rc - yc));
                        cmd[1] = 16'(clamp_cmd(t + pc + rc + yc));
                        cmd[2] = 16'(clamp_cmd(t - pc - rc + yc));
                        cmd[3] = 16'(clamp_cmd(t - pc + rc - yc));
                    end
                end
                default: begin
                    ra = longint'(r.roll_ang);
                    pa = longint'(r.pitch_ang);
                    if (ra < 0) ra = -ra;
                    if (pa < 0) pa = -pa;
                    if (ra > longint'(cfg.tilt_limit) || pa > longint'(cfg.tilt_limit)) begin
                        disarm();
                        exp_set.tilt_ok = 1'b0;
                    end
                end
            endcase
            if (armed) begin
                exp_set.rear_right  = cmd_to_pulse(cmd[2]);
                exp_set.front_left  = cmd_to_pulse(cmd[1]);
                exp_set.front_right = cmd_to_pulse(cmd[0]);
                exp_set.rear_left   = cmd_to_pulse(cmd[3]);
            end else begin
                exp_set.rear_right  = cfg.pulse_min;
                exp_set.front_left  = cfg.pulse_min;
                exp_set.front_right = cfg.pulse_min;
                exp_set.rear_left   = cfg.pulse_min;
            end
            exp_set.armed = armed;
            pulse_due.push_back(exp_set);
        endfunction

        function void compare_field(string name, longint expv, longint actv);
            if (expv != actv) begin
                $error("%s: expected %0d, actual %0d", name, expv, actv);
                mismatches++;
            end
        endfunction

        function void check_pulses(t_pulse_set got);
            t_pulse_set want;
            if (pulse_due.size() == 0) begin
                $error("result beat with no request outstanding");
                mismatches++;
                return;
            end
            want = pulse_due.pop_front();
            compare_field("pulse_rear_right", want.rear_right, got.rear_right);
            compare_field("pulse_front_left", want.front_left, got.front_left);
            compare_field("pulse_front_right", want.front_right, got.front_right);
            compare_field("pulse_rear_left", want.rear_left, got.rear_left);
            compare_field("is_armed", want.armed, got.armed);
            compare_field("tilt_ok", want.tilt_ok, got.tilt_ok);
        endfunction

        function int pending();
            return pulse_due.size();
        endfunction
    endclass

    logic                 i_clk          = 1'b0;
    logic                 i_rst_n        = 1'b0;
    logic                 i_valid        = 1'b0;
    logic                 o_stall;
    logic [1:0]           i_req_type     = REQ_ARM;
    logic signed [15:0]   i_throttle_cmd = '0;
    logic signed [15:0]   i_roll_effort  = '0;
    logic signed [15:0]   i_pitch_effort = '0;
    logic signed [15:0]   i_yaw_effort   = '0;
    logic signed [11:0]   i_roll_angle   = '0;
    logic signed [11:0]   i_pitch_angle  = '0;
    logic                 o_valid;
    logic                 i_stall        = 1'b0;
    logic [11:0]          o_pulse_rear_right;
    logic [11:0]          o_pulse_front_left;
    logic [11:0]          o_pulse_front_right;
    logic [11:0]          o_pulse_rear_left;
    logic                 o_is_armed;
    logic                 o_tilt_ok;
    logic                 i_cfg_valid    = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_AW-1:0]    i_cfg_index    = '0;
    logic [CFG_DW-1:0]    i_cfg_data     = '0;

    motor_pulse_tracker tracker = new();
    int  quiet_cycles = 0;
    bit  calm         = 1'b0;   // no idling on either side
    bit  rx_hold_req  = 1'b0;

    always #4 i_clk = ~i_clk;

    quad_x_motor_mixer #(
        .EFFORT_FRACTION_BITS (FRAC_BITS)
    ) u_dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_stall             (o_stall),
        .i_req_type          (i_req_type),
        .i_throttle_cmd      (i_throttle_cmd),
        .i_roll_effort       (i_roll_effort),
        .i_pitch_effort      (i_pitch_effort),
        .i_yaw_effort        (i_yaw_effort),
        .i_roll_angle        (i_roll_angle),
        .i_pitch_angle       (i_pitch_angle),
        .o_valid             (o_valid),
        .i_stall             (i_stall),
        .o_pulse_rear_right  (o_pulse_rear_right),
        .o_pulse_front_left  (o_pulse_front_left),
        .o_pulse_front_right (o_pulse_front_right),
        .o_pulse_rear_left   (o_pulse_rear_left),
        .o_is_armed          (o_is_armed),
        .o_tilt_ok           (o_tilt_ok),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data)
    );

    // beat monitor: request noted before result so a same-edge pair stays in order
    always @(posedge i_clk) begin
        t_mix_req   taken;
        t_pulse_set seen;
        bit         any_beat;
        any_beat = 1'b0;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                tracker.apply_reg(t_reg_idx'(i_cfg_index), i_cfg_data);
                any_beat = 1'b1;
            end
            if (i_valid && !o_stall) begin
                taken.req       = t_req'(i_req_type);
                taken.throttle  = i_throttle_cmd;
                taken.roll      = i_roll_effort;
                taken.pitch     = i_pitch_effort;
                taken.yaw       = i_yaw_effort;
                taken.roll_ang  = i_roll_angle;
                taken.pitch_ang = i_pitch_angle;
                tracker.note_request(taken);
                any_beat = 1'b1;
            end
            if (o_valid && !i_stall) begin
                seen.rear_right  = o_pulse_rear_right;
                seen.front_left  = o_pulse_front_left;
                seen.front_right = o_pulse_front_right;
                seen.rear_left   = o_pulse_rear_left;
                seen.armed       = o_is_armed;
                seen.tilt_ok     = o_tilt_ok;
                tracker.check_pulses(seen);
                any_beat = 1'b1;
            end
            quiet_cycles <= any_beat ? 0 : quiet_cycles + 1;
        end
    end

    initial begin
        while (quiet_cycles < WATCHDOG_LIMIT) @(posedge i_clk);
        $display("tb failed");
        $finish;
    end

    // result side back-pressure
    initial begin
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (rx_hold_req) begin
                i_stall <= 1'b1;
                repeat (RX_HOLD_CYCLES) @(posedge i_clk);
                rx_hold_req = 1'b0;
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 7)) @(posedge i_clk);
            end else begin
                i_stall <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
        end
    end

    function automatic t_mix_req mk(t_req req, int thr, int rl, int pt, int yw,
                                    int ra, int pa);
        t_mix_req r;
        r.req       = req;
        r.throttle  = thr[15:0];
        r.roll      = rl[15:0];
        r.pitch     = pt[15:0];
        r.yaw       = yw[15:0];
        r.roll_ang  = ra[11:0];
        r.pitch_ang = pa[11:0];
        return r;
    endfunction

    function automatic logic signed [15:0] rand_effort();
        int v;
        case ($urandom_range(0, 3))
            0, 1:    v = int'($urandom_range(0, 2047)) - 1024;
            2:       v = int'($urandom_range(0, 16383)) - 8192;
            default: v = int'($urandom());
        endcase
        return v[15:0];
    endfunction

    function automatic logic signed [11:0] rand_angle(logic [10:0] lim);
        int v;
        case ($urandom_range(0, 9))
            0:       v = int'(lim);
            1, 2:    v = int'($urandom_range(0, 1800));
            default: v = int'($urandom_range(0, lim));
        endcase
        if ($urandom_range(0, 1)) v = -v;
        return v[11:0];
    endfunction

    // mostly arm -> mixes -> tilt checks, with some disarms and noise
    function automatic t_mix_req random_req(bit armed, logic [10:0] lim);
        t_mix_req r;
        int       pick;
        int       thr;
        pick = $urandom_range(0, 99);
        if (!armed)
            r.req = (pick < 60) ? REQ_ARM : t_req'($urandom_range(0, 3));
        else if (pick < 5)
            r.req = REQ_ARM;
        else if (pick < 10)
            r.req = REQ_DISARM;
        else if (pick < 75)
            r.req = REQ_MIX;
        else
            r.req = REQ_TILT;
        thr = ($urandom_range(0, 3) == 0) ? int'($urandom()) :
                                            int'($urandom_range(0, 1400)) - 100;
        r.throttle  = thr[15:0];
        r.roll      = rand_effort();
        r.pitch     = rand_effort();
        r.yaw       = rand_effort();
        r.roll_ang  = rand_angle(lim);
        r.pitch_ang = rand_angle(lim);
        return r;
    endfunction

    function automatic t_cfg phase_cfg(int ph);
        t_cfg c;
        case (ph)
            1: begin
                c = '{cmd_min: 15'd100, cmd_max: 15'd900, full_scale: 15'd1000,
                      pulse_min: 12'd1000, pulse_range: 12'd1000, pulse_max: 12'd2000,
                      tilt_limit: 11'd300, gain: 8'd128};
            end
            2: begin
                c = '{cmd_min: 15'd0, cmd_max: 15'h7fff, full_scale: 15'h7fff,
                      pulse_min: 12'hfff, pulse_range: 12'hfff, pulse_max: 12'hfff,
                      tilt_limit: 11'd1800, gain: 8'hff};
            end
            3: begin
                // zero full scale acts as one
                c = '{cmd_min: 15'd0, cmd_max: 15'd0, full_scale: 15'd0,
                      pulse_min: 12'd0, pulse_range: 12'd0, pulse_max: 12'd0,
                      tilt_limit: 11'd0, gain: 8'd0};
            end
            4: begin
                // inverted command range and pulse cap below pulse_min
                c = '{cmd_min: 15'd2000, cmd_max: 15'd500, full_scale: 15'd1,
                      pulse_min: 12'd1500, pulse_range: 12'hfff, pulse_max: 12'd1200,
                      tilt_limit: 11'd900, gain: 8'd1};
            end
            default: begin
                c.cmd_min     = 15'($urandom_range(0, 600));
                c.cmd_max     = 15'($urandom_range(400, 1500));
                c.full_scale  = 15'($urandom_range(1, 2000));
                c.pulse_min   = 12'($urandom_range(800, 1200));
                c.pulse_range = 12'($urandom_range(0, 2000));
                c.pulse_max   = 12'($urandom_range(1500, 4095));
                c.tilt_limit  = 11'($urandom_range(0, 1800));
                c.gain        = 8'($urandom_range(0, 255));
            end
        endcase
        return c;
    endfunction

    task automatic send_req(t_mix_req r);
        if (!calm && $urandom_range(0, 4) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_req_type     <= r.req;
        i_throttle_cmd <= r.throttle;
        i_roll_effort  <= r.roll;
        i_pitch_effort <= r.pitch;
        i_yaw_effort   <= r.yaw;
        i_roll_angle   <= r.roll_ang;
        i_pitch_angle  <= r.pitch_ang;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (tracker.pending() != 0) @(posedge i_clk);
    endtask

    task automatic program_regs(t_cfg c);
        logic [CFG_DW-1:0] vals [8];
        vals[REG_CMD_MIN]    = c.cmd_min;
        vals[REG_CMD_MAX]    = c.cmd_max;
        vals[REG_FULL_SCALE] = c.full_scale;
        vals[REG_PULSE_MIN]  = CFG_DW'(c.pulse_min);
        vals[REG_PULSE_RNG]  = CFG_DW'(c.pulse_range);
        vals[REG_PULSE_MAX]  = CFG_DW'(c.pulse_max);
        vals[REG_TILT_LIM]   = CFG_DW'(c.tilt_limit);
        vals[REG_GAIN]       = CFG_DW'(c.gain);
        for (int k = 0; k < 8; k++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= k[CFG_AW-1:0];
            i_cfg_data  <= vals[k];
            @(posedge i_clk);
            while (!o_cfg_ready) @(posedge i_clk);
        end
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin
        t_mix_req opening [$];
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset registers: min 0, max 800, full scale 1000, tilt 450, gain 50
        opening.push_back(mk(REQ_MIX, 500, 100, 100, 100, 0, 0));      // mix while disarmed
        opening.push_back(mk(REQ_TILT, 0, 0, 0, 0, 0, 0));
        opening.push_back(mk(REQ_ARM, 0, 0, 0, 0, 0, 0));
        opening.push_back(mk(REQ_ARM, 0, 0, 0, 0, 0, 0));              // already armed
        opening.push_back(mk(REQ_MIX, 400, 0, 0, 0, 0, 0));
        opening.push_back(mk(REQ_MIX, 32767, 32767, -32768, 32767, 1800, -1800));
        opening.push_back(mk(REQ_MIX, -32768, -32768, 32767, -32768, -1800, 1800));
        opening.push_back(mk(REQ_MIX, 400, -6, 5, -1, 0, 0));          // rounding toward zero
        opening.push_back(mk(REQ_MIX, 400, -512, 300, 700, 0, 0));
        opening.push_back(mk(REQ_TILT, 0, 0, 0, 0, 450, -450));        // right at the limit
        opening.push_back(mk(REQ_TILT, 0, 0, 0, 0, -451, 0));          // just past it
        opening.push_back(mk(REQ_ARM, 0, 0, 0, 0, 0, 0));              // commands were cleared
        opening.push_back(mk(REQ_MIX, 300, 1000, 2000, -3000, 0, 0));
        opening.push_back(mk(REQ_TILT, 0, 0, 0, 0, 0, 451));
        opening.push_back(mk(REQ_ARM, 0, 0, 0, 0, 0, 0));
        opening.push_back(mk(REQ_MIX, 700, -2000, -1000, 500, 0, 0));
        opening.push_back(mk(REQ_DISARM, 0, 0, 0, 0, 0, 0));
        opening.push_back(mk(REQ_DISARM, 0, 0, 0, 0, 0, 0));
        opening.push_back(mk(REQ_ARM, 0, 0, 0, 0, 0, 0));
        opening.push_back(mk(REQ_MIX, 0, 0, 0, 0, 0, 0));
        opening.push_back(mk(REQ_TILT, 0, 0, 0, 0, 1800, -1800));
        opening.push_back(mk(REQ_MIX, 32767, -1, -1, -1, -1, -1));
        foreach (opening[k]) send_req(opening[k]);

        for (int ph = 0; ph < PHASES; ph++) begin
            if (ph > 0) begin
                wait_drained();
                program_regs(phase_cfg(ph));
            end
            calm = (ph == PHASES - 1);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (ph == 1 && n == 50) rx_hold_req = 1'b1;
                if (ph == 2 && n == 100) wait_drained();
                send_req(random_req(tracker.armed, tracker.cfg.tilt_limit));
            end
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (tracker.mismatches == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule
